>>> rtl/erot_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package erot_pkg;

    localparam int COORD_WIDTH_DEF    = 32;
    localparam int TRIG_FRAC_BITS_DEF = 15;
    localparam int ANGLE_WIDTH        = 16;

    localparam int Q30_BITS = 30;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    localparam int TURN      = 23040;
    localparam int HALF_TURN = 11520;
    localparam int QUARTER   = 5760;
    localparam int OCTANT    = 2880;

    localparam logic [18:0] PI_QUOT = 19'd292817;
    localparam logic [11:0] PI_REM  = 12'd3793;
    localparam logic [16:0] INV45   = 17'd93207;

    localparam int SIN_CELLS = 4;
    localparam int COS_CELLS = 5;
    localparam int SIN_DIVS [SIN_CELLS] = '{72, 42, 20, 6};
    localparam int COS_DIVS [COS_CELLS] = '{90, 56, 30, 12, 2};

    localparam int LAT_TRIG = 15;
    localparam int LAT_ROT  = 2;
    localparam int LAT_ALL  = LAT_TRIG + 3 * LAT_ROT;

    typedef struct packed {
        logic [7:0]  k;
        logic [31:0] m;
        logic [7:0]  s;
    } t_recip;

    function automatic t_recip recip_of(input int d);
        t_recip r;
        case (d)
            72:      r = '{8'd3, 32'd1908874354, 8'd34};
            42:      r = '{8'd1, 32'd1636178018, 8'd35};
            20:      r = '{8'd2, 32'd1717986919, 8'd33};
            6:       r = '{8'd1, 32'd1431655766, 8'd32};
            90:      r = '{8'd1, 32'd1527099484, 8'd36};
            56:      r = '{8'd3, 32'd1227133514, 8'd33};
            30:      r = '{8'd1, 32'd1145324613, 8'd34};
            12:      r = '{8'd2, 32'd1431655766, 8'd32};
            2:       r = '{8'd1, 32'd1, 8'd0};
            default: r = '{8'd0, 32'd1, 8'd0};
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/erot_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface erot_in_if #(
    parameter int COORD_WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [15:0]      angle_x;
    logic signed [15:0]      angle_y;
    logic signed [15:0]      angle_z;

    modport source (output valid, point_x, point_y, point_z, angle_x, angle_y, angle_z,
                    input ready);
    modport sink (input valid, point_x, point_y, point_z, angle_x, angle_y, angle_z,
                  output ready);
endinterface

interface erot_out_if #(
    parameter int COORD_WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    logic signed [COORD_WIDTH-1:0] rot_x;
    logic signed [COORD_WIDTH-1:0] rot_y;
    logic signed [COORD_WIDTH-1:0] rot_z;

    modport source (output valid, rot_x, rot_y, rot_z, input ready);
    modport sink (input valid, rot_x, rot_y, rot_z, output ready);
endinterface
`default_nettype wire

>>> rtl/erot_horner_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module erot_horner_cell #(
    parameter int DIVISOR = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [29:0] i_x2,
    input  wire logic [30:0] i_t,
    output logic      [29:0] o_x2,
    output logic      [30:0] o_t
);
    import erot_pkg::*;

    localparam t_recip RC = recip_of(DIVISOR);

    logic [60:0] w_p;
    logic [29:0] n_v, r_v;
    logic [29:0] r_x2a, r_x2b;
    logic [61:0] w_q;
    logic [30:0] n_t, r_t;

    assign w_p = 61'(i_x2) * 61'(i_t);
    assign n_v = w_p[59:30] >> RC.k;
    assign w_q = 62'(r_v) * 62'(RC.m);
    assign n_t = Q30_ONE - 31'(w_q >> RC.s);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v   <= n_v;
            r_x2a <= i_x2;
            r_t   <= n_t;
            r_x2b <= r_x2a;
        end
    end

    assign o_x2 = r_x2b;
    assign o_t  = r_t;
endmodule
`default_nettype wire

>>> rtl/erot_trig.sv
`timescale 1ns / 1ps
`default_nettype none
module erot_trig #(
    parameter int TRIG_FRAC_BITS = erot_pkg::TRIG_FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic signed [15:0]             i_angle,
    output logic signed [TRIG_FRAC_BITS+1:0]    o_sin,
    output logic signed [TRIG_FRAC_BITS+1:0]    o_cos
);
    import erot_pkg::*;

    localparam int F  = TRIG_FRAC_BITS;
    localparam int SH = Q30_BITS - F;
    localparam int QD = LAT_TRIG - 2;
    localparam int XD = 8;

    logic [16:0] w_u0, w_u1, w_u2;
    logic [14:0] w_r;
    logic [1:0]  n_q;
    logic [12:0] w_rem;
    logic        n_swap;
    logic [11:0] n_b, r_b;
    logic [1:0]  r_q [QD+1];
    logic        r_swap [QD+1];

    logic [29:0] r_pa;
    logic [16:0] r_m;
    logic [23:0] w_bm;
    logic [33:0] w_dq;
    logic [29:0] r_x3;
    logic [59:0] w_xx;
    logic [29:0] r_x4, r_x2;
    logic [29:0] r_xd [XD];

    logic [29:0] w_sx2 [SIN_CELLS+1];
    logic [30:0] w_st  [SIN_CELLS+1];
    logic [29:0] w_cx2 [COS_CELLS+1];
    logic [30:0] w_ct  [COS_CELLS+1];

    logic [60:0] w_xt;
    logic [30:0] r_sp, r_sp2;
    logic [F:0]  w_sm, w_cm, w_s1, w_c1;
    logic signed [F+1:0] n_sin, n_cos, w_s1s, w_c1s;

    always_comb begin
        w_u0 = 17'(i_angle + 17'sd46080);
        w_u1 = (w_u0 >= 17'd46080) ? w_u0 - 17'd46080 : w_u0;
        w_u2 = (w_u1 >= 17'd23040) ? w_u1 - 17'd23040 : w_u1;
        w_r  = w_u2[14:0];
        if (w_r >= 15'd17280) begin
            n_q = 2'd3;
            w_rem = 13'(w_r - 15'd17280);
        end else if (w_r >= 15'd11520) begin
            n_q = 2'd2;
            w_rem = 13'(w_r - 15'd11520);
        end else if (w_r >= 15'd5760) begin
            n_q = 2'd1;
            w_rem = 13'(w_r - 15'd5760);
        end else begin
            n_q = 2'd0;
            w_rem = w_r[12:0];
        end
        n_swap = w_rem > 13'(OCTANT);
        n_b    = n_swap ? 12'(13'(QUARTER) - w_rem) : w_rem[11:0];
    end

    assign w_bm = 24'(r_b) * 24'(PI_REM);
    assign w_dq = 34'(r_m) * 34'(INV45);
    assign w_xx = 60'(r_x3) * 60'(r_x3);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b       <= n_b;
            r_q[0]    <= n_q;
            r_swap[0] <= n_swap;
            for (int i = 1; i <= QD; i++) begin
                r_q[i]    <= r_q[i-1];
                r_swap[i] <= r_swap[i-1];
            end
            r_pa  <= 30'(31'(r_b) * 31'(PI_QUOT));
            r_m   <= w_bm[23:7];
            r_x3  <= r_pa + 30'(w_dq >> 22);
            r_x4  <= r_x3;
            r_x2  <= w_xx[59:30];
            r_xd[0] <= r_x4;
            for (int i = 1; i < XD; i++) begin
                r_xd[i] <= r_xd[i-1];
            end
            r_sp  <= w_xt[60:30];
            r_sp2 <= r_sp;
            o_sin <= n_sin;
            o_cos <= n_cos;
        end
    end

    assign w_sx2[0] = r_x2;
    assign w_st[0]  = Q30_ONE;
    assign w_cx2[0] = r_x2;
    assign w_ct[0]  = Q30_ONE;

    for (genvar g = 0; g < SIN_CELLS; g++) begin : g_sin
        erot_horner_cell #(.DIVISOR(SIN_DIVS[g])) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x2  (w_sx2[g]),
            .i_t   (w_st[g]),
            .o_x2  (w_sx2[g+1]),
            .o_t   (w_st[g+1])
        );
    end

    for (genvar g = 0; g < COS_CELLS; g++) begin : g_cos
        erot_horner_cell #(.DIVISOR(COS_DIVS[g])) u_cell (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_x2  (w_cx2[g]),
            .i_t   (w_ct[g]),
            .o_x2  (w_cx2[g+1]),
            .o_t   (w_ct[g+1])
        );
    end

    assign w_xt = 61'(r_xd[XD-1]) * 61'(w_st[SIN_CELLS]);

    if (SH == 0) begin : g_nornd
        assign w_sm = r_sp2[F:0];
        assign w_cm = w_ct[COS_CELLS][F:0];
    end else begin : g_rnd
        logic [31:0] w_sr, w_cr;
        assign w_sr = 32'(r_sp2) + (32'd1 << (SH - 1));
        assign w_cr = 32'(w_ct[COS_CELLS]) + (32'd1 << (SH - 1));
        assign w_sm = w_sr[SH+F:SH];
        assign w_cm = w_cr[SH+F:SH];
    end

    always_comb begin
        w_s1  = r_swap[QD] ? w_cm : w_sm;
        w_c1  = r_swap[QD] ? w_sm : w_cm;
        w_s1s = $signed({1'b0, w_s1});
        w_c1s = $signed({1'b0, w_c1});
        case (r_q[QD])
            2'd0: begin
                n_sin = w_s1s;
                n_cos = w_c1s;
            end
            2'd1: begin
                n_sin = w_c1s;
                n_cos = -w_s1s;
            end
            2'd2: begin
                n_sin = -w_s1s;
                n_cos = -w_c1s;
            end
            default: begin
                n_sin = -w_c1s;
                n_cos = w_s1s;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/erot_rot_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module erot_rot_cell #(
    parameter int COORD_WIDTH    = erot_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = erot_pkg::TRIG_FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_en,
    input  wire logic signed [COORD_WIDTH-1:0]     i_a,
    input  wire logic signed [COORD_WIDTH-1:0]     i_b,
    input  wire logic signed [COORD_WIDTH-1:0]     i_p,
    input  wire logic signed [TRIG_FRAC_BITS+1:0]  i_sin,
    input  wire logic signed [TRIG_FRAC_BITS+1:0]  i_cos,
    output logic signed [COORD_WIDTH-1:0]          o_a,
    output logic signed [COORD_WIDTH-1:0]          o_b,
    output logic signed [COORD_WIDTH-1:0]          o_p
);
    localparam int W  = COORD_WIDTH;
    localparam int F  = TRIG_FRAC_BITS;
    localparam int PW = W + F + 2;

    logic signed [PW-1:0] r_ac, r_bs, r_as, r_bc;
    logic signed [W-1:0]  r_p1;
    logic signed [W+2:0]  w_na, w_nb;
    logic signed [W-1:0]  n_a, n_b;

    function automatic logic signed [W-1:0] sat(input logic signed [W+2:0] v);
        logic signed [W-1:0] r;
        if (v[W+2:W-1] == '0 || v[W+2:W-1] == '1) begin
            r = v[W-1:0];
        end else begin
            r = v[W+2] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        return r;
    endfunction

    assign w_na = (W+3)'($signed(r_ac[PW-1:F])) - (W+3)'($signed(r_bs[PW-1:F]));
    assign w_nb = (W+3)'($signed(r_as[PW-1:F])) + (W+3)'($signed(r_bc[PW-1:F]));
    assign n_a  = sat(w_na);
    assign n_b  = sat(w_nb);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ac <= PW'(i_a) * PW'(i_cos);
            r_bs <= PW'(i_b) * PW'(i_sin);
            r_as <= PW'(i_a) * PW'(i_sin);
            r_bc <= PW'(i_b) * PW'(i_cos);
            r_p1 <= i_p;
            o_a  <= n_a;
            o_b  <= n_b;
            o_p  <= r_p1;
        end
    end
endmodule
`default_nettype wire

>>> rtl/euler_rotation_3d.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Modport  Direction  Payload
// i_pt     sink     in         point_x, point_y, point_z, angle_x, angle_y, angle_z
// o_rot    source   out        rot_x, rot_y, rot_z
//
// One point is taken per cycle while ready is high; each result then passes through
// the 15-stage sine and cosine pipeline, three 2-stage rotation cells
// and the output register.
// Reset clears only the valid bits of the pipeline and of the output stage.
// The pipeline advances while the two-entry output stage has room, so a new
// transfer is taken while a finished result waits.
module euler_rotation_3d #(
    parameter int COORD_WIDTH    = erot_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = erot_pkg::TRIG_FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    erot_in_if.sink   i_pt,
    erot_out_if.source o_rot
);
    import erot_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int F = TRIG_FRAC_BITS;

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
    } t_point;

    logic w_en;
    logic [LAT_ALL-1:0] r_vld;
    t_point r_pd [LAT_TRIG];
    logic signed [F+1:0] w_sx, w_cx, w_sy, w_cy, w_sz, w_cz;
    logic signed [F+1:0] r_sy [LAT_ROT];
    logic signed [F+1:0] r_cy [LAT_ROT];
    logic signed [F+1:0] r_sz [2*LAT_ROT];
    logic signed [F+1:0] r_cz [2*LAT_ROT];
    logic signed [W-1:0] w_y1, w_z1, w_x1, w_z2, w_x2, w_y2, w_x3, w_y3, w_z3;
    t_point w_res, r_out, r_skid;
    logic r_ov, r_sv, w_take;

    assign w_en       = !r_sv;
    assign i_pt.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT_ALL-2:0], i_pt.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pd[0] <= '{i_pt.point_x, i_pt.point_y, i_pt.point_z};
            for (int i = 1; i < LAT_TRIG; i++) begin
                r_pd[i] <= r_pd[i-1];
            end
            r_sy[0] <= w_sy;
            r_cy[0] <= w_cy;
            for (int i = 1; i < LAT_ROT; i++) begin
                r_sy[i] <= r_sy[i-1];
                r_cy[i] <= r_cy[i-1];
            end
            r_sz[0] <= w_sz;
            r_cz[0] <= w_cz;
            for (int i = 1; i < 2 * LAT_ROT; i++) begin
                r_sz[i] <= r_sz[i-1];
                r_cz[i] <= r_cz[i-1];
            end
        end
    end

    erot_trig #(.TRIG_FRAC_BITS(F)) u_trig_x (
        .i_clk (i_clk), .i_en (w_en), .i_angle (i_pt.angle_x), .o_sin (w_sx), .o_cos (w_cx)
    );
    erot_trig #(.TRIG_FRAC_BITS(F)) u_trig_y (
        .i_clk (i_clk), .i_en (w_en), .i_angle (i_pt.angle_y), .o_sin (w_sy), .o_cos (w_cy)
    );
    erot_trig #(.TRIG_FRAC_BITS(F)) u_trig_z (
        .i_clk (i_clk), .i_en (w_en), .i_angle (i_pt.angle_z), .o_sin (w_sz), .o_cos (w_cz)
    );

    erot_rot_cell #(.COORD_WIDTH(W), .TRIG_FRAC_BITS(F)) u_rot_x (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (r_pd[LAT_TRIG-1].y), .i_b (r_pd[LAT_TRIG-1].z), .i_p (r_pd[LAT_TRIG-1].x),
        .i_sin (w_sx), .i_cos (w_cx),
        .o_a (w_y1), .o_b (w_z1), .o_p (w_x1)
    );
    erot_rot_cell #(.COORD_WIDTH(W), .TRIG_FRAC_BITS(F)) u_rot_y (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (w_z1), .i_b (w_x1), .i_p (w_y1),
        .i_sin (r_sy[LAT_ROT-1]), .i_cos (r_cy[LAT_ROT-1]),
        .o_a (w_z2), .o_b (w_x2), .o_p (w_y2)
    );
    erot_rot_cell #(.COORD_WIDTH(W), .TRIG_FRAC_BITS(F)) u_rot_z (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (w_x2), .i_b (w_y2), .i_p (w_z2),
        .i_sin (r_sz[2*LAT_ROT-1]), .i_cos (r_cz[2*LAT_ROT-1]),
        .o_a (w_x3), .o_b (w_y3), .o_p (w_z3)
    );

    assign w_res  = '{w_x3, w_y3, w_z3};
    assign w_take = r_ov && o_rot.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_take) begin
                r_sv <= 1'b0;
            end
        end else if (r_vld[LAT_ALL-1]) begin
            if (!r_ov || w_take) begin
                r_ov <= 1'b1;
            end else begin
                r_sv <= 1'b1;
            end
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (r_vld[LAT_ALL-1]) begin
            if (!r_ov || w_take) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_rot.valid = r_ov;
    assign o_rot.rot_x = r_out.x;
    assign o_rot.rot_y = r_out.y;
    assign o_rot.rot_z = r_out.z;
endmodule
`default_nettype wire
